/* sv/gas_fire_alarm_controller_core_macros.svh */
// Assertion macros for the gas and fire alarm controller checker.
`ifndef GAS_FIRE_ALARM_CONTROLLER_CORE_MACROS_SVH
`define GAS_FIRE_ALARM_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset
`define GFAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define GFAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/gfac_pkg.sv */
// ----------------------------------------------------------------------------
// gfac_pkg
// Types and constants shared by the gas and fire alarm controller.
// ----------------------------------------------------------------------------
package gfac_pkg;

	localparam int READING_W    = 10;
	localparam int NUM_READINGS = 5;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int HOLD_W       = 16;
	localparam int COOL_W       = 32;
	localparam int BLINK_W      = 16;

	typedef logic [1:0] level_t;
	localparam level_t LEVEL_SAFE  = 2'd0;
	localparam level_t LEVEL_SMOKE = 2'd1;
	localparam level_t LEVEL_GAS   = 2'd2;
	localparam level_t LEVEL_FIRE  = 2'd3;

	// bit 2 red, bit 1 green, bit 0 blue
	typedef logic [2:0] color_t;
	localparam color_t COLOR_OFF   = 3'b000;
	localparam color_t COLOR_GREEN = 3'b010;
	localparam color_t COLOR_SMOKE = 3'b110;
	localparam color_t COLOR_GAS   = 3'b101;
	localparam color_t COLOR_FIRE  = 3'b100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SMOKE_THR  = 3'd0,
		CFG_GAS_THR    = 3'd1,
		CFG_FIRE_THR   = 3'd2,
		CFG_GAS_HOLD   = 3'd3,
		CFG_ALERT_COOL = 3'd4,
		CFG_BLINK_HALF = 3'd5
	} cfg_idx_t;

	localparam logic [READING_W-1:0] RST_SMOKE_THR  = 10'd380;
	localparam logic [READING_W-1:0] RST_GAS_THR    = 10'd420;
	localparam logic [READING_W-1:0] RST_FIRE_THR   = 10'd600;
	localparam logic [HOLD_W-1:0]    RST_GAS_HOLD   = 16'd5000;
	localparam logic [COOL_W-1:0]    RST_ALERT_COOL = 32'd10000;
	localparam logic [BLINK_W-1:0]   RST_BLINK_HALF = 16'd500;

	typedef struct packed {
		logic                 sample_valid;
		logic [READING_W-1:0] gas_reading_a;
		logic [READING_W-1:0] gas_reading_b;
		logic [READING_W-1:0] gas_reading_c;
		logic [READING_W-1:0] gas_reading_d;
		logic [READING_W-1:0] gas_reading_e;
		logic [READING_W-1:0] flame_reading;
	} in_item_t;

	typedef struct packed {
		level_t               alarm_level;
		logic [READING_W-1:0] gas_average;
		logic                 red_lamp;
		logic                 rgb_red;
		logic                 rgb_green;
		logic                 rgb_blue;
		logic                 play_alarm;
		logic                 stop_alarm;
		logic                 send_alert;
	} out_item_t;

endpackage

/* sv/gas_fire_alarm_controller_core.sv */
// ----------------------------------------------------------------------------
// gas_fire_alarm_controller_core
// Gas and fire alarm controller: one beat per millisecond tick, one result
// beat per tick with level, averaged gas, lamp and sound/alert pulses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_ready   | in_data  (in_item_t)
//  out     | out       | out_valid / out_ready | out_data (out_item_t)
//  cfg     | in        | cfg_we                | cfg_addr, cfg_wdata
//
// One beat per cycle while the output accepts; a result passes through the input
// register, then the result register.
// The whole tick update sits between the input register and the result
// register; a skid entry lets one more beat in while the output stalls.
// Reset clears all alarm state and loads the default thresholds; no sweep.
// ----------------------------------------------------------------------------
module gas_fire_alarm_controller_core
	import gfac_pkg::*;
#(
	parameter int GAS_SAMPLES = 5,
	parameter int TIME_BITS   = 32,
	parameter int ADC_BITS    = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	in_item_t             item_s1;
	logic                 valid_s1;
	logic                 buf_ready, adv;
	logic [READING_W-1:0] gas_avg, flame;
	out_item_t            result;

	assign adv      = valid_s1 && buf_ready;
	assign in_ready = !valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	gfac_avg #(
		.GAS_SAMPLES (GAS_SAMPLES),
		.ADC_BITS    (ADC_BITS)
	) u_avg (
		.item    (item_s1),
		.gas_avg (gas_avg),
		.flame   (flame)
	);

	gfac_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.step         (adv),
		.sample_valid (item_s1.sample_valid),
		.gas_avg      (gas_avg),
		.flame        (flame),
		.result       (result)
	);

	gfac_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (adv),
		.push_data  (result),
		.push_ready (buf_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

/* sv/gfac_avg.sv */
// ----------------------------------------------------------------------------
// gfac_avg
// Averages the gas readings of one sample and masks the flame reading.
// ----------------------------------------------------------------------------
module gfac_avg
	import gfac_pkg::*;
#(
	parameter int GAS_SAMPLES = 5,
	parameter int ADC_BITS    = 10
) (
	input  in_item_t             item,
	output logic [READING_W-1:0] gas_avg,
	output logic [READING_W-1:0] flame
);

	localparam int SAMPLE_COUNT = (GAS_SAMPLES < 1) ? 1 :
		((GAS_SAMPLES > NUM_READINGS) ? NUM_READINGS : GAS_SAMPLES);
	localparam int SUM_W = READING_W + 3;
	localparam logic [READING_W-1:0] ADC_MASK = READING_W'((64'd1 << ADC_BITS) - 64'd1);
	// rounded-up reciprocal of the count; exact floor for any sum below 2^14
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
	localparam int PROD_W      = SUM_W + RECIP_SHIFT + 1;

	logic [READING_W-1:0] rd [NUM_READINGS];
	logic [SUM_W-1:0]     sum;
	logic [PROD_W-1:0]    prod;

	assign rd[0] = item.gas_reading_a;
	assign rd[1] = item.gas_reading_b;
	assign rd[2] = item.gas_reading_c;
	assign rd[3] = item.gas_reading_d;
	assign rd[4] = item.gas_reading_e;

	always_comb begin
		sum = '0;
		for (int i = 0; i < SAMPLE_COUNT; i++) begin
			sum = sum + SUM_W'(rd[i] & ADC_MASK);
		end
	end

	// truncating divide by the constant count as a reciprocal multiply
	assign prod    = PROD_W'(sum) * PROD_W'(RECIP);
	assign gas_avg = prod[RECIP_SHIFT +: READING_W];
	assign flame   = item.flame_reading & ADC_MASK;

endmodule

/* sv/gfac_core.sv */
// ----------------------------------------------------------------------------
// gfac_core
// Config registers, alarm state and the per-tick classify / hold / lamp /
// alert update.
// ----------------------------------------------------------------------------
module gfac_core
	import gfac_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  step,
	input  logic                  sample_valid,
	input  logic [READING_W-1:0]  gas_avg,
	input  logic [READING_W-1:0]  flame,
	output out_item_t             result
);

	localparam int CMP_W = (TIME_BITS > COOL_W) ? TIME_BITS : COOL_W;

	logic [READING_W-1:0] smoke_thr_q, gas_thr_q, fire_thr_q;
	logic [HOLD_W-1:0]    gas_hold_q;
	logic [COOL_W-1:0]    alert_cool_q;
	logic [BLINK_W-1:0]   blink_half_q;

	logic [TIME_BITS-1:0] tick_q, hold_start_q, last_alert_q, last_toggle_q;
	logic [READING_W-1:0] held_gas_q, held_flame_q;
	level_t               prev_level_q;
	logic                 hold_running_q, alert_done_q, sound_on_q, blink_phase_q;
	color_t               lamp_q;

	// next-state values
	logic [TIME_BITS-1:0] hold_start_d, last_alert_d, last_toggle_d;
	logic [READING_W-1:0] gas_d, flame_d;
	level_t               level;
	logic                 hold_running_d, alert_done_d, sound_on_d, blink_phase_d;
	color_t               lamp_d, color;
	logic                 changed, play, alert, toggle;
	logic [TIME_BITS-1:0] hold_el, toggle_el, alert_el;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoke_thr_q  <= RST_SMOKE_THR;
			gas_thr_q    <= RST_GAS_THR;
			fire_thr_q   <= RST_FIRE_THR;
			gas_hold_q   <= RST_GAS_HOLD;
			alert_cool_q <= RST_ALERT_COOL;
			blink_half_q <= RST_BLINK_HALF;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_SMOKE_THR:  smoke_thr_q  <= cfg_wdata[READING_W-1:0];
				CFG_GAS_THR:    gas_thr_q    <= cfg_wdata[READING_W-1:0];
				CFG_FIRE_THR:   fire_thr_q   <= cfg_wdata[READING_W-1:0];
				CFG_GAS_HOLD:   gas_hold_q   <= cfg_wdata[HOLD_W-1:0];
				CFG_ALERT_COOL: alert_cool_q <= cfg_wdata[COOL_W-1:0];
				CFG_BLINK_HALF: blink_half_q <= cfg_wdata[BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		gas_d   = sample_valid ? gas_avg : held_gas_q;
		flame_d = sample_valid ? flame   : held_flame_q;

		if (flame_d >= fire_thr_q)     level = LEVEL_FIRE;
		else if (gas_d >= gas_thr_q)   level = LEVEL_GAS;
		else if (gas_d >= smoke_thr_q) level = LEVEL_SMOKE;
		else                           level = LEVEL_SAFE;

		// gas falling back to smoke is held at gas for gas_hold ticks
		hold_start_d   = hold_start_q;
		hold_running_d = 1'b0;
		hold_el        = '0;
		if (prev_level_q == LEVEL_GAS && level == LEVEL_SMOKE) begin
			if (!hold_running_q) hold_start_d = tick_q;
			hold_el = tick_q - hold_start_d;
			if (hold_el < TIME_BITS'(gas_hold_q)) begin
				level          = LEVEL_GAS;
				hold_running_d = 1'b1;
			end
		end

		changed      = (level != prev_level_q);
		alert_done_d = changed ? 1'b0 : alert_done_q;
		sound_on_d   = changed ? 1'b0 : sound_on_q;

		case (level)
			LEVEL_SMOKE: color = COLOR_SMOKE;
			LEVEL_GAS:   color = COLOR_GAS;
			default:     color = COLOR_FIRE;
		endcase

		toggle_el     = tick_q - last_toggle_q;
		toggle        = 1'b0;
		play          = 1'b0;
		lamp_d        = lamp_q;
		blink_phase_d = blink_phase_q;
		last_toggle_d = last_toggle_q;
		if (level == LEVEL_SAFE) begin
			lamp_d = COLOR_GREEN;
		end else begin
			toggle = (toggle_el >= TIME_BITS'(blink_half_q));
			if (toggle) begin
				last_toggle_d = tick_q;
				blink_phase_d = !blink_phase_q;
				lamp_d        = blink_phase_d ? color : COLOR_OFF;
			end
			play       = !sound_on_d;
			sound_on_d = 1'b1;
		end

		alert_el     = tick_q - last_alert_q;
		alert        = (level != LEVEL_SAFE) && !alert_done_d &&
			(CMP_W'(alert_el) > CMP_W'(alert_cool_q));
		last_alert_d = last_alert_q;
		if (alert) begin
			alert_done_d = 1'b1;
			last_alert_d = tick_q;
		end

		result.alarm_level = level;
		result.gas_average = gas_d;
		result.red_lamp    = level[1];
		result.rgb_red     = lamp_d[2];
		result.rgb_green   = lamp_d[1];
		result.rgb_blue    = lamp_d[0];
		result.play_alarm  = play;
		result.stop_alarm  = changed;
		result.send_alert  = alert;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= '0;
			held_gas_q     <= '0;
			held_flame_q   <= '0;
			prev_level_q   <= LEVEL_SAFE;
			hold_running_q <= 1'b0;
			hold_start_q   <= '0;
			alert_done_q   <= 1'b0;
			sound_on_q     <= 1'b0;
			last_alert_q   <= '0;
			last_toggle_q  <= '0;
			blink_phase_q  <= 1'b0;
			lamp_q         <= COLOR_GREEN;
		end else if (step) begin
			tick_q         <= tick_q + 1'b1;
			held_gas_q     <= gas_d;
			held_flame_q   <= flame_d;
			prev_level_q   <= level;
			hold_running_q <= hold_running_d;
			hold_start_q   <= hold_start_d;
			alert_done_q   <= alert_done_d;
			sound_on_q     <= sound_on_d;
			last_alert_q   <= last_alert_d;
			last_toggle_q  <= last_toggle_d;
			blink_phase_q  <= blink_phase_d;
			lamp_q         <= lamp_d;
		end
	end

endmodule

/* sv/gfac_outbuf.sv */
// ----------------------------------------------------------------------------
// gfac_outbuf
// Result register with a skid entry, so a stalled output does not stop the
// next beat being computed.
// ----------------------------------------------------------------------------
module gfac_outbuf
	import gfac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      push_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      out_valid_q, skid_valid_q;
	out_item_t out_q, skid_q;
	logic      pop;

	assign pop        = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else                     out_valid_q  <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= push_data;
			else                     out_q  <= push_data;
		end
	end

endmodule

/* sv/gfac_checker.sv */
// ----------------------------------------------------------------------------
// gfac_checker
// Port-level checks for the gas and fire alarm controller, bound to the top.
// ----------------------------------------------------------------------------
`include "gas_fire_alarm_controller_core_macros.svh"

module gfac_checker
	import gfac_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic out_beat, out_stall, play_beat, safe_beat, green_only;
	assign out_beat   = out_valid && out_ready;
	assign out_stall  = out_valid && !out_ready;
	assign play_beat  = out_beat && out_data.play_alarm;
	assign safe_beat  = out_beat && out_data.alarm_level == LEVEL_SAFE;
	assign green_only = out_data.rgb_green && !out_data.rgb_red && !out_data.rgb_blue;

	// a stalled result beat holds
	`GFAC_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled beat changed")

	// input only backs up when a result is waiting
	`GFAC_ASSERT_IMP(a_bp_cause, !in_ready, out_valid, "input stalled with no result pending")

	`GFAC_ASSERT_IMP(a_play_lvl, play_beat, out_data.alarm_level != LEVEL_SAFE, "play at safe level")

	`GFAC_ASSERT_IMP(a_red_lamp, out_beat, out_data.red_lamp == out_data.alarm_level[1], "red lamp off")

	`GFAC_ASSERT_IMP(a_safe_green, safe_beat, green_only, "lamp not green at safe level")

endmodule

bind gas_fire_alarm_controller_core gfac_checker u_gfac_checker (.*);

/* test/gas_fire_alarm_controller_core_tb.sv */
// ----------------------------------------------------------------------------
// gas_fire_alarm_controller_core_tb
// Self-checking bench for the alarm controller. Tick beats go in with random
// gaps while the result side stalls at random. A scoreboard keeps its own
// copy of the alarm state, predicts each result beat and compares it field
// by field. Directed ticks come first, then random phases under several
// threshold, hold, cooldown and blink settings, the extremes among them.
// ----------------------------------------------------------------------------
module gas_fire_alarm_controller_core_tb;
	import gfac_pkg::*;

	localparam int LIMIT_TIME  = 2_000_000;
	localparam int TAIL_CYCLES = 8;
	localparam int LONG_STALL  = 300;
	localparam int STALL_AT    = 400;
	localparam int PHASE_TICKS = 130;
	localparam int RAND_PHASES = 8;
	localparam int READING_MAX = (1 << READING_W) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

	class alarm_tracker;
		logic [READING_W-1:0] smoke_thr, gas_thr, fire_thr;
		logic [HOLD_W-1:0]    hold_len;
		logic [COOL_W-1:0]    cooldown;
		logic [BLINK_W-1:0]   blink_half;
		logic [31:0]          now_tick, hold_since, alert_at, toggle_at;
		logic [READING_W-1:0] avg_gas, flame;
		level_t               last_level;
		bit                   holding, alerted, sounding, blink_on;
		color_t               lamp;
		out_item_t            pending_results[$];
		int                   fails, results_seen;

		function new();
			smoke_thr    = RST_SMOKE_THR;
			gas_thr      = RST_GAS_THR;
			fire_thr     = RST_FIRE_THR;
			hold_len     = RST_GAS_HOLD;
			cooldown     = RST_ALERT_COOL;
			blink_half   = RST_BLINK_HALF;
			now_tick     = '0;
			hold_since   = '0;
			alert_at     = '0;
			toggle_at    = '0;
			avg_gas      = '0;
			flame        = '0;
			last_level   = LEVEL_SAFE;
			holding      = 1'b0;
			alerted      = 1'b0;
			sounding     = 1'b0;
			blink_on     = 1'b0;
			lamp         = COLOR_GREEN;
			fails        = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_SMOKE_THR:  smoke_thr  = value[READING_W-1:0];
				CFG_GAS_THR:    gas_thr    = value[READING_W-1:0];
				CFG_FIRE_THR:   fire_thr   = value[READING_W-1:0];
				CFG_GAS_HOLD:   hold_len   = value[HOLD_W-1:0];
				CFG_ALERT_COOL: cooldown   = value[COOL_W-1:0];
				CFG_BLINK_HALF: blink_half = value[BLINK_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted tick beat -> one expected result beat
		function void note_tick(in_item_t it);
			logic [12:0] gas_sum;
			logic [31:0] span;
			level_t      lvl;
			color_t      hue;
			out_item_t   res;
			res = '0;
			if (it.sample_valid) begin
				gas_sum = 13'(it.gas_reading_a) + 13'(it.gas_reading_b) +
					13'(it.gas_reading_c) + 13'(it.gas_reading_d) + 13'(it.gas_reading_e);
				avg_gas = READING_W'(gas_sum / NUM_READINGS);
				flame   = it.flame_reading;
			end

			if (flame >= fire_thr) lvl = LEVEL_FIRE;
			else if (avg_gas >= gas_thr) lvl = LEVEL_GAS;
			else if (avg_gas >= smoke_thr) lvl = LEVEL_SMOKE;
			else lvl = LEVEL_SAFE;

			// gas falling back to smoke stays at gas until the hold runs out
			if (last_level == LEVEL_GAS && lvl == LEVEL_SMOKE) begin
				if (!holding) begin
					holding    = 1'b1;
					hold_since = now_tick;
				end
				span = now_tick - hold_since;
				if (span < 32'(hold_len)) lvl = LEVEL_GAS;
				else holding = 1'b0;
			end else begin
				holding = 1'b0;
			end

			if (lvl != last_level) begin
				alerted        = 1'b0;
				sounding       = 1'b0;
				res.stop_alarm = 1'b1;
				last_level     = lvl;
			end

			if (lvl == LEVEL_SAFE) begin
				lamp = COLOR_GREEN;
			end else begin
				case (lvl)
					LEVEL_SMOKE: hue = COLOR_SMOKE;
					LEVEL_GAS:   hue = COLOR_GAS;
					default:     hue = COLOR_FIRE;
				endcase
				res.red_lamp = (lvl == LEVEL_GAS || lvl == LEVEL_FIRE);
				span = now_tick - toggle_at;
				if (span >= 32'(blink_half)) begin
					toggle_at = now_tick;
					blink_on  = !blink_on;
					lamp      = blink_on ? hue : COLOR_OFF;
				end
				if (!sounding) begin
					res.play_alarm = 1'b1;
					sounding       = 1'b1;
				end
			end

			span = now_tick - alert_at;
			if (lvl != LEVEL_SAFE && !alerted && span > cooldown) begin
				res.send_alert = 1'b1;
				alerted        = 1'b1;
				alert_at       = now_tick;
			end

			res.alarm_level = lvl;
			res.gas_average = avg_gas;
			{res.rgb_red, res.rgb_green, res.rgb_blue} = lamp;
			pending_results.push_back(res);
			now_tick = now_tick + 32'd1;
		endfunction

		function void compare(string field, logic [READING_W-1:0] want,
				logic [READING_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				fails++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result beat with no expected result waiting");
				fails++;
				return;
			end
			want = pending_results.pop_front();
			compare("alarm_level", want.alarm_level, got.alarm_level);
			compare("gas_average", want.gas_average, got.gas_average);
			compare("red_lamp", want.red_lamp, got.red_lamp);
			compare("rgb_red", want.rgb_red, got.rgb_red);
			compare("rgb_green", want.rgb_green, got.rgb_green);
			compare("rgb_blue", want.rgb_blue, got.rgb_blue);
			compare("play_alarm", want.play_alarm, got.play_alarm);
			compare("stop_alarm", want.stop_alarm, got.stop_alarm);
			compare("send_alert", want.send_alert, got.send_alert);
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	alarm_tracker tracker = new();
	bit           tx_steady       = 1'b0;
	bit           rx_steady       = 1'b0;
	bit           long_stall_done = 1'b0;

	gas_fire_alarm_controller_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// mostly back to back or short gaps, now and then a long one
	function automatic int idle_len(bit steady);
		int roll;
		if (steady) return 0;
		roll = $urandom_range(99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(3, 1);
		if (roll < 97) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [READING_W-1:0] near(int centre, int spread);
		int v;
		v = centre + int'($urandom_range(2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > READING_MAX) v = READING_MAX;
		return v[READING_W-1:0];
	endfunction

	function automatic in_item_t uniform_tick(bit fresh, int gas, int flame_level);
		in_item_t it;
		it.sample_valid  = fresh;
		it.gas_reading_a = READING_W'(gas);
		it.gas_reading_b = READING_W'(gas);
		it.gas_reading_c = READING_W'(gas);
		it.gas_reading_d = READING_W'(gas);
		it.gas_reading_e = READING_W'(gas);
		it.flame_reading = READING_W'(flame_level);
		return it;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] with_junk(int width, int unsigned value);
		logic [CFG_DATA_W-1:0] w;
		w = $urandom;
		return (w << width) | value;
	endfunction

	task automatic send_tick(in_item_t it);
		int gap;
		gap = idle_len(tx_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_tick(it);
		@(negedge clk);
	endtask

	// wait for every result beat, then give the pipeline time to empty
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		tracker.write_reg(idx, value);
	endtask

	task automatic apply_config(logic [CFG_DATA_W-1:0] smoke, logic [CFG_DATA_W-1:0] gas,
			logic [CFG_DATA_W-1:0] fire, logic [CFG_DATA_W-1:0] hold,
			logic [CFG_DATA_W-1:0] cool, logic [CFG_DATA_W-1:0] blink);
		write_reg(CFG_SMOKE_THR, smoke);
		write_reg(CFG_GAS_THR, gas);
		write_reg(CFG_FIRE_THR, fire);
		write_reg(CFG_GAS_HOLD, hold);
		write_reg(CFG_ALERT_COOL, cool);
		write_reg(CFG_BLINK_HALF, blink);
		// unused indexes must leave everything alone
		write_reg(CFG_SPARE_6, $urandom);
		write_reg(CFG_SPARE_7, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_phase(int idx);
		int smoke;
		smoke = $urandom_range(600, 150);
		case (idx)
			0: apply_config(32'd380, 32'd420, 32'd600, 32'd25, 32'd40, 32'd3);
			1: apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
			2: apply_config('1, '1, '1, '1, '1, '1);
			3: apply_config(32'd600, 32'd300, 32'd800, 32'd5, 32'd10, 32'd1);
			default: apply_config(with_junk(READING_W, smoke),
				with_junk(READING_W, smoke + $urandom_range(120)),
				with_junk(READING_W, $urandom_range(900, 300)),
				with_junk(HOLD_W, $urandom_range(40)),
				$urandom_range(80),
				with_junk(BLINK_W, $urandom_range(12)));
		endcase
		tx_steady = ($urandom_range(3) == 0);
		rx_steady = ($urandom_range(3) == 0);
	endtask

	// runs of ticks hovering around the thresholds, salted with raw noise
	task automatic run_random(int count);
		int          left, run_len, gas_c, flame_c, spread;
		logic [63:0] raw;
		in_item_t    it;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(30, 1);
			spread  = $urandom_range(8);
			case ($urandom_range(5))
				0: gas_c = int'(tracker.smoke_thr);
				1: gas_c = int'(tracker.gas_thr);
				2: gas_c = (int'(tracker.smoke_thr) + int'(tracker.gas_thr)) / 2;
				3: gas_c = int'(tracker.gas_thr) + 20;
				4: gas_c = int'(tracker.smoke_thr) - 30;
				default: gas_c = $urandom_range(READING_MAX);
			endcase
			case ($urandom_range(9))
				0, 1: flame_c = int'(tracker.fire_thr);
				2: flame_c = $urandom_range(READING_MAX);
				default: flame_c = int'(tracker.fire_thr) / 2;
			endcase
			while (run_len > 0 && left > 0) begin
				if ($urandom_range(99) < 10) begin
					raw = {$urandom, $urandom};
					it  = raw[$bits(in_item_t)-1:0];
				end else begin
					it.sample_valid  = ($urandom_range(99) < 80);
					it.gas_reading_a = near(gas_c, spread);
					it.gas_reading_b = near(gas_c, spread);
					it.gas_reading_c = near(gas_c, spread);
					it.gas_reading_d = near(gas_c, spread);
					it.gas_reading_e = near(gas_c, spread);
					it.flame_reading = near(flame_c, spread);
				end
				send_tick(it);
				run_len--;
				left--;
			end
		end
	endtask

	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_stall_done && tracker.results_seen >= STALL_AT) begin
				// hold off long enough for the block to back up into its input
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_done = 1'b1;
			end else begin
				stall = idle_len(rx_steady);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			tracker.check_result(out_data);
		end
	end

	initial begin : watchdog
		#(LIMIT_TIME);
		$display("[gas_fire_alarm_controller_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		in_item_t it;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset thresholds: field extremes and the band edges
		send_tick(uniform_tick(1'b1, 0, 0));
		send_tick(uniform_tick(1'b1, READING_MAX, READING_MAX));
		it = '1;
		it.sample_valid = 1'b0;
		send_tick(it);
		send_tick(uniform_tick(1'b1, 450, 0));
		send_tick(uniform_tick(1'b1, 400, 0));
		send_tick(uniform_tick(1'b1, 100, 599));
		send_tick(uniform_tick(1'b1, 0, 600));
		it = uniform_tick(1'b1, READING_MAX, 0);
		it.gas_reading_e = READING_W'(READING_MAX - 1);
		send_tick(it);
		// average truncates just below the smoke threshold
		it = uniform_tick(1'b1, 380, 0);
		it.gas_reading_a = 10'd379;
		it.gas_reading_e = 10'd379;
		it.gas_reading_c = 10'd381;
		send_tick(it);

		// short hold, quick cooldown, lamp toggling every tick
		drain();
		apply_config(32'd380, 32'd420, 32'd600, 32'd2, 32'd1, 32'd0);
		send_tick(uniform_tick(1'b1, 450, 0));
		send_tick(uniform_tick(1'b1, 400, 0));
		send_tick(uniform_tick(1'b0, 0, 0));
		send_tick(uniform_tick(1'b0, 0, 0));
		send_tick(uniform_tick(1'b1, 450, 0));
		send_tick(uniform_tick(1'b1, 400, 700));
		send_tick(uniform_tick(1'b1, 400, 0));
		send_tick(uniform_tick(1'b1, 0, 0));
		send_tick(uniform_tick(1'b1, 390, 0));
		send_tick(uniform_tick(1'b0, 0, 0));
		send_tick(uniform_tick(1'b0, 0, 0));
		send_tick(uniform_tick(1'b1, 500, 0));
		send_tick(uniform_tick(1'b1, 0, 0));

		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			setup_phase(p);
			run_random(PHASE_TICKS);
		end

		drain();
		if (tracker.fails == 0 && tracker.pending_results.size() == 0) begin
			$display("[gas_fire_alarm_controller_core] OK");
		end else begin
			$display("[gas_fire_alarm_controller_core] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/gfac_pkg.sv
sv/gfac_avg.sv
sv/gfac_core.sv
sv/gfac_outbuf.sv
sv/gas_fire_alarm_controller_core.sv
sv/gfac_checker.sv
test/gas_fire_alarm_controller_core_tb.sv
